/* src/fpe_pkg.sv */
// Shared types, constants and codes of the fern posterior engine.
`timescale 1ns / 1ps
`default_nettype none
package fpe_pkg;
   localparam int TREE_COUNT_DEF   = 10;
   localparam int FEATURE_BITS_DEF = 13;
   localparam int COUNT_WIDTH_DEF  = 16;
   localparam int MAX_TREES        = 10;
   localparam int CODE_W           = 13;
   localparam int THR_W            = 20;
   localparam int WEIGHT_W         = 17;
   localparam int FRAC_W           = 16;
   localparam logic [THR_W-1:0] POS_THR_RESET = 20'd393216;
   localparam logic [THR_W-1:0] NEG_THR_RESET = 20'd327680;

   typedef enum logic [1:0] {
      FUNC_EVAL   = 2'd0,
      FUNC_TRAIN  = 2'd1,
      FUNC_DIRECT = 2'd2,
      FUNC_SPARE  = 2'd3
   } func_type;

   typedef enum logic {
      CSR_POS_THR = 1'b0,
      CSR_NEG_THR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] func;
      logic       label;
      logic [CODE_W-1:0] tree_code_0;
      logic [CODE_W-1:0] tree_code_1;
      logic [CODE_W-1:0] tree_code_2;
      logic [CODE_W-1:0] tree_code_3;
      logic [CODE_W-1:0] tree_code_4;
      logic [CODE_W-1:0] tree_code_5;
      logic [CODE_W-1:0] tree_code_6;
      logic [CODE_W-1:0] tree_code_7;
      logic [CODE_W-1:0] tree_code_8;
      logic [CODE_W-1:0] tree_code_9;
   } req_type;

   typedef struct packed {
      logic [THR_W-1:0] confidence_sum;
      logic             learned;
   } rsp_type;

   // sequencer to lane control
   typedef struct packed {
      logic clear;    // write zero at the addressed leaf
      logic rd;       // take table read data into the count registers
      logic upd;      // write back bumped counts and new weight
      logic label;
   } lane_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_SUM, ST_DIV, ST_WRITE, ST_OUT
   } state_type;
endpackage
`default_nettype wire

/* src/fpe_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module fpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

/* src/fpe_lane.sv */
// One tree lane: count and weight tables plus a bit-serial ratio divider.
`timescale 1ns / 1ps
`default_nettype none
module fpe_lane #(
   parameter int FEATURE_BITS = fpe_pkg::FEATURE_BITS_DEF,
   parameter int COUNT_WIDTH  = fpe_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fpe_pkg::lane_ctl_type    ctl,
   input  wire logic                     div_start,
   input  wire logic [FEATURE_BITS-1:0]  addr,
   output      logic [fpe_pkg::WEIGHT_W-1:0] weight,
   output      logic                     div_busy
);
   import fpe_pkg::*;
   localparam int SUM_W = COUNT_WIDTH + 1;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   logic [COUNT_WIDTH-1:0] pos_rd, neg_rd, pos_wr, neg_wr;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in, neg_ff, neg_in;
   logic [WEIGHT_W-1:0] w_wr;
   logic we;

   assign we     = ctl.clear | ctl.upd;
   assign pos_wr = ctl.clear ? '0 : pos_ff;
   assign neg_wr = ctl.clear ? '0 : neg_ff;

   fpe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(2**FEATURE_BITS)) u_pos (
      .clock, .we, .addr, .wdata(pos_wr), .rdata(pos_rd));
   fpe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(2**FEATURE_BITS)) u_neg (
      .clock, .we, .addr, .wdata(neg_wr), .rdata(neg_rd));
   fpe_ram #(.WIDTH(WEIGHT_W), .DEPTH(2**FEATURE_BITS)) u_wgt (
      .clock, .we, .addr, .wdata(w_wr), .rdata(weight));

   // counts after the bump, captured when the read data lands
   always_comb begin
      pos_in = pos_ff;
      neg_in = neg_ff;
      if (ctl.rd) begin
         pos_in = pos_rd;
         neg_in = neg_rd;
      end
      if (div_start) begin
         if (ctl.label) pos_in = (pos_ff == CMAX) ? CMAX : pos_ff + 1'b1;
         else           neg_in = (neg_ff == CMAX) ? CMAX : neg_ff + 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      neg_ff <= neg_in;
   end

   // restoring divider: (pos << 16) / (pos + neg), one quotient bit a cycle
   logic [SUM_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] num_ff, num_in;
   logic [WEIGHT_W-1:0] q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [SUM_W:0] trial;

   assign trial = {rem_ff, (cnt_ff <= 6'(FRAC_W)) ? 1'b0 : num_ff[COUNT_WIDTH-1]};
   always_comb begin
      den_in = den_ff; rem_in = rem_ff; num_in = num_ff; q_in = q_ff; cnt_in = cnt_ff;
      if (div_start) begin
         den_in = SUM_W'(pos_in) + SUM_W'(neg_in);
         rem_in = '0;
         num_in = pos_in;
         q_in   = '0;
         cnt_in = 6'(COUNT_WIDTH + FRAC_W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = SUM_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[WEIGHT_W-2:0], 1'b1};
         end else begin
            rem_in = SUM_W'(trial);
            q_in   = {q_ff[WEIGHT_W-2:0], 1'b0};
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
      den_ff <= den_in; rem_ff <= rem_in; num_ff <= num_in; q_ff <= q_in;
   end
   assign div_busy = (cnt_ff != '0);
   assign w_wr = (ctl.clear || pos_ff == '0) ? '0 : q_ff;
endmodule
`default_nettype wire

/* src/fpe_merge.sv */
// Sums the lane weights through a registered two-level tree.
`timescale 1ns / 1ps
`default_nettype none
module fpe_merge #(
   parameter int TREE_COUNT = fpe_pkg::TREE_COUNT_DEF
) (
   input  wire logic clock,
   input  wire logic [TREE_COUNT-1:0][fpe_pkg::WEIGHT_W-1:0] weights,
   output      logic [fpe_pkg::THR_W-1:0] sum
);
   import fpe_pkg::*;
   localparam int HALF = (TREE_COUNT + 1) / 2;
   logic [THR_W-1:0] a_ff, b_ff, a_in, b_in;
   always_comb begin
      a_in = '0;
      b_in = '0;
      for (int t = 0; t < TREE_COUNT; t++) begin
         if (t < HALF) a_in = a_in + THR_W'(weights[t]);
         else          b_in = b_in + THR_W'(weights[t]);
      end
   end
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end
   assign sum = a_ff + b_ff;
endmodule
`default_nettype wire

/* src/fern_posterior_engine.sv */
// Top level of the fern posterior engine: sequencer, lanes and merge.
// Usage:
//  A request on req_ carries func, label and one leaf code per tree. Each tree
//  has its own lane (count and weight memories, divider); all lanes read in
//  parallel and the merge stage sums their weights. One response on rsp_ per
//  request gives the pre-update confidence_sum and whether counts were learned.
//  Requests that do not learn go through table read and sum to the response;
//  learning requests also run the 32-step bit-serial ratio divider in each
//  lane (COUNT_WIDTH+16 steps) and the write-back before the response.
//  One request is in flight at a time; req_stall is high while busy.
//  After reset the block sweeps 2^FEATURE_BITS leaves to clear every table,
//  holding req_stall high; CSR writes are taken meanwhile.
//  Thresholds reset to 6.0 and 5.0 in Q4.16. If the receiver stalls, the
//  response is held in its output register and no new request is taken.
`timescale 1ns / 1ps
`default_nettype none
module fern_posterior_engine #(
   parameter int TREE_COUNT   = fpe_pkg::TREE_COUNT_DEF,
   parameter int FEATURE_BITS = fpe_pkg::FEATURE_BITS_DEF,
   parameter int COUNT_WIDTH  = fpe_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire fpe_pkg::req_type   req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      fpe_pkg::rsp_type   rsp_data,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [fpe_pkg::THR_W-1:0] csr_wdata
);
   import fpe_pkg::*;

   state_type state_ff, state_in;
   logic [THR_W-1:0] pthr_ff, nthr_ff;
   logic [MAX_TREES-1:0][CODE_W-1:0] codes;
   logic [TREE_COUNT-1:0][FEATURE_BITS-1:0] addr_ff, addr_in;
   logic [FEATURE_BITS-1:0] clr_ff;
   logic label_ff, learn_in;
   func_type func_ff;
   rsp_type rsp_ff;
   logic [TREE_COUNT-1:0][WEIGHT_W-1:0] weights;
   logic [TREE_COUNT-1:0] busy;
   logic [THR_W-1:0] sum;
   lane_ctl_type ctl;
   logic div_start, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         pthr_ff <= POS_THR_RESET;
         nthr_ff <= NEG_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_POS_THR: pthr_ff <= csr_wdata;
            CSR_NEG_THR: nthr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign codes = {req_data.tree_code_9, req_data.tree_code_8, req_data.tree_code_7,
                   req_data.tree_code_6, req_data.tree_code_5, req_data.tree_code_4,
                   req_data.tree_code_3, req_data.tree_code_2, req_data.tree_code_1,
                   req_data.tree_code_0};
   assign accept = req_valid && !req_stall;
   always_comb begin
      addr_in = addr_ff;
      if (accept)
         for (int t = 0; t < TREE_COUNT; t++)
            addr_in[t] = FEATURE_BITS'(codes[t] & CODE_W'((2**FEATURE_BITS) - 1));
      // sweep address runs level with clr_ff
      if (state_ff == ST_CLEAR)
         for (int t = 0; t < TREE_COUNT; t++) addr_in[t] = FEATURE_BITS'(clr_ff + 1'b1);
   end

   always_comb begin
      learn_in = 1'b0;
      unique case (func_ff)
         FUNC_TRAIN:  learn_in = label_ff ? (sum <= pthr_ff) : (sum >= nthr_ff);
         FUNC_DIRECT: learn_in = 1'b1;
         default:     learn_in = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_READ;
         ST_READ:  state_in = ST_WAIT;
         ST_WAIT:  state_in = ST_SUM;
         ST_SUM:   state_in = learn_in ? ST_DIV : ST_OUT;
         ST_DIV:   if (busy == '0) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl       = '0;
      ctl.label = label_ff;
      ctl.clear = (state_ff == ST_CLEAR);
      ctl.rd    = (state_ff == ST_WAIT);
      ctl.upd   = (state_ff == ST_WRITE);
      div_start = (state_ff == ST_SUM) && learn_in;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         addr_ff <= addr_in;
      end
      if (accept) begin
         label_ff <= req_data.label;
         func_ff  <= func_type'(req_data.func);
      end
      if (state_ff == ST_SUM) begin
         rsp_ff.confidence_sum <= sum;
         rsp_ff.learned        <= learn_in;
      end
   end
   assign rsp_data = rsp_ff;

   for (genvar t = 0; t < TREE_COUNT; t++) begin : g_lane
      fpe_lane #(.FEATURE_BITS(FEATURE_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_lane (
         .clock, .reset, .ctl, .div_start, .addr(addr_ff[t]),
         .weight(weights[t]), .div_busy(busy[t]));
   end

   fpe_merge #(.TREE_COUNT(TREE_COUNT)) u_merge (.clock, .weights, .sum);

   a_one_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ) else $error("request not started");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
   a_no_div_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.learned |-> busy == '0) else $error("divider busy");
endmodule
`default_nettype wire
